>>> rtl/shp_pkg.sv
package shp_pkg;

  localparam int MAX_WIDTH    = 1024;
  localparam int MAX_HEIGHT   = 4096;
  localparam int MAX_CHANNELS = 3;
  localparam int MIN_DIM      = 3;
  localparam int PIX_W        = 8;

  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int ROW_W    = $clog2(MAX_HEIGHT);
  localparam int WIDTH_W  = 11;
  localparam int HEIGHT_W = 13;
  localparam int CHCNT_W  = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd2;

  localparam logic [WIDTH_W-1:0]  RST_IMAGE_WIDTH   = 11'd640;
  localparam logic [HEIGHT_W-1:0] RST_IMAGE_HEIGHT  = 13'd480;
  localparam logic [CHCNT_W-1:0]  RST_CHANNEL_COUNT = 2'd3;

  typedef logic [MAX_CHANNELS-1:0][PIX_W-1:0] pix_t;

  typedef struct packed {
    logic [PIX_W-1:0] chan_a;
    logic [PIX_W-1:0] chan_b;
    logic [PIX_W-1:0] chan_c;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] out_a;
    logic [PIX_W-1:0] out_b;
    logic [PIX_W-1:0] out_c;
    logic             run_last;
    logic             frame_end;
  } out_item_t;

  // per-item control carried alongside the pixel in the read stage
  typedef struct packed {
    logic             emit;
    logic             interior;
    logic             row_end;
    logic             frame_last;
    logic [COL_W-1:0] col;
  } item_ctrl_t;

endpackage

>>> rtl/sharpen_3x3_cross_filter.sv
// channel | direction | payload            | handshake
// in_     | input     | in_item_t (3 x 8b) | in_valid / in_ready
// out_    | output    | out_item_t         | out_valid / out_ready
// cfg_    | input     | index 2b, data 13b | cfg_valid / cfg_ready (always ready)
//
// one input transaction per cycle while the output side is not held; an input
// passes the line store read stage, then the result register, to out_valid
// an input at a row's last column yields two results and so holds the output
// side until the border result is taken; inputs in row 0 or column 0 yield none
// synchronous active-low reset clears counters, window and configuration;
// line stores are not cleared, their unwritten entries never reach a result
// a stalled output backs up through the read stage into in_ready
module sharpen_3x3_cross_filter (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  shp_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output shp_pkg::out_item_t            out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [shp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [shp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import shp_pkg::*;

  // configuration registers
  logic [WIDTH_W-1:0]  image_width_r;
  logic [HEIGHT_W-1:0] image_height_r;
  logic [CHCNT_W-1:0]  channel_count_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r   <= RST_IMAGE_WIDTH;
      image_height_r  <= RST_IMAGE_HEIGHT;
      channel_count_r <= RST_CHANNEL_COUNT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:   image_width_r   <= cfg_data[WIDTH_W-1:0];
        REG_IMAGE_HEIGHT:  image_height_r  <= cfg_data[HEIGHT_W-1:0];
        REG_CHANNEL_COUNT: channel_count_r <= cfg_data[CHCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped frame geometry
  logic [WIDTH_W-1:0]  eff_w;
  logic [HEIGHT_W-1:0] eff_h;
  logic [CHCNT_W-1:0]  eff_nch;
  logic [WIDTH_W-1:0]  w_last;
  logic [HEIGHT_W-1:0] h_last;

  always_comb begin
    if (image_width_r < WIDTH_W'(MIN_DIM)) begin
      eff_w = WIDTH_W'(MIN_DIM);
    end else if (image_width_r > WIDTH_W'(MAX_WIDTH)) begin
      eff_w = WIDTH_W'(MAX_WIDTH);
    end else begin
      eff_w = image_width_r;
    end
    if (image_height_r < HEIGHT_W'(MIN_DIM)) begin
      eff_h = HEIGHT_W'(MIN_DIM);
    end else if (image_height_r > HEIGHT_W'(MAX_HEIGHT)) begin
      eff_h = HEIGHT_W'(MAX_HEIGHT);
    end else begin
      eff_h = image_height_r;
    end
    if (channel_count_r == '0) begin
      eff_nch = CHCNT_W'(1);
    end else if (channel_count_r > CHCNT_W'(MAX_CHANNELS)) begin
      eff_nch = CHCNT_W'(MAX_CHANNELS);
    end else begin
      eff_nch = channel_count_r;
    end
  end

  assign w_last = eff_w - WIDTH_W'(1);
  assign h_last = eff_h - HEIGHT_W'(1);

  // raster position of the next input
  logic [COL_W-1:0] col_r;
  logic [ROW_W-1:0] row_r;

  // read stage: pixel waiting for its line store data
  logic       s1_valid_r;
  pix_t       s1_pix_r;
  item_ctrl_t s1_ctrl_r;
  item_ctrl_t ctrl_nxt;
  pix_t       in_pix;

  logic accept;
  logic s1_adv;
  logic can_load;

  assign in_pix[0] = in_data.chan_a;
  assign in_pix[1] = in_data.chan_b;
  assign in_pix[2] = in_data.chan_c;

  always_comb begin
    ctrl_nxt.col        = col_r;
    ctrl_nxt.row_end    = {1'b0, col_r} >= w_last;
    ctrl_nxt.frame_last = ctrl_nxt.row_end && ({1'b0, row_r} >= h_last);
    ctrl_nxt.emit       = (row_r != '0) && (col_r != '0);
    ctrl_nxt.interior   = (row_r >= ROW_W'(2)) && (col_r >= COL_W'(2))
                       && ({1'b0, col_r} <= w_last);
  end

  assign s1_adv   = s1_valid_r && (!s1_ctrl_r.emit || can_load);
  assign in_ready = !s1_valid_r || s1_adv;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_r <= 1'b1;
        if (ctrl_nxt.frame_last) begin
          col_r <= '0;
          row_r <= '0;
        end else if (ctrl_nxt.row_end) begin
          col_r <= '0;
          row_r <= row_r + ROW_W'(1);
        end else begin
          col_r <= col_r + COL_W'(1);
        end
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix_r  <= in_pix;
      s1_ctrl_r <= ctrl_nxt;
    end
  end

  // line stores: read on accept, written as the item leaves the read stage;
  // consecutive items never share a column so no read-write clash occurs
  pix_t up_rd;
  pix_t mid_rd;

  shp_line_ram u_upper (
    .clk     (clk),
    .wr_en   (s1_adv),
    .wr_addr (s1_ctrl_r.col),
    .wr_data (mid_rd),
    .rd_en   (accept),
    .rd_addr (col_r),
    .rd_data (up_rd)
  );

  shp_line_ram u_middle (
    .clk     (clk),
    .wr_en   (s1_adv),
    .wr_addr (s1_ctrl_r.col),
    .wr_data (s1_pix_r),
    .rd_en   (accept),
    .rd_addr (col_r),
    .rd_data (mid_rd)
  );

  // window and arithmetic
  pix_t res;

  shp_kernel u_kernel (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (s1_adv),
    .pix      (s1_pix_r),
    .up       (up_rd),
    .mid      (mid_rd),
    .interior (s1_ctrl_r.interior),
    .nch      (eff_nch),
    .res      (res)
  );

  // first result of the transaction; the border result follows on row end
  out_item_t first_item;

  always_comb begin
    first_item.out_a     = res[0];
    first_item.out_b     = res[1];
    first_item.out_c     = res[2];
    first_item.run_last  = !s1_ctrl_r.row_end;
    first_item.frame_end = 1'b0;
  end

  shp_out_buf u_out (
    .clk         (clk),
    .rst_n       (rst_n),
    .load        (s1_adv && s1_ctrl_r.emit),
    .load_item   (first_item),
    .load_border (s1_ctrl_r.row_end),
    .load_fe     (s1_ctrl_r.frame_last),
    .can_load    (can_load),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule

>>> rtl/shp_line_ram.sv
module shp_line_ram (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [shp_pkg::COL_W-1:0] wr_addr,
  input  shp_pkg::pix_t            wr_data,
  input  logic                     rd_en,
  input  logic [shp_pkg::COL_W-1:0] rd_addr,
  output shp_pkg::pix_t            rd_data
);
  import shp_pkg::*;

  pix_t mem [MAX_WIDTH];
  pix_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/shp_kernel.sv
module shp_kernel (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       adv,
  input  shp_pkg::pix_t              pix,
  input  shp_pkg::pix_t              up,
  input  shp_pkg::pix_t              mid,
  input  logic                       interior,
  input  logic [shp_pkg::CHCNT_W-1:0] nch,
  output shp_pkg::pix_t              res
);
  import shp_pkg::*;

  // window columns: 0 is one column back, 1 is two columns back
  pix_t up0_r, mid0_r, mid1_r, low0_r, low1_r, up1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      up0_r  <= '0;
      up1_r  <= '0;
      mid0_r <= '0;
      mid1_r <= '0;
      low0_r <= '0;
      low1_r <= '0;
    end else if (adv) begin
      up1_r  <= up0_r;
      mid1_r <= mid0_r;
      low1_r <= low0_r;
      up0_r  <= up;
      mid0_r <= mid;
      low0_r <= pix;
    end
  end

  // 5*centre minus left, right, upper and lower, saturated; zero off the interior and for unused channels
  always_comb begin
    logic [PIX_W+2:0]   ctr5;
    logic [PIX_W+1:0]   nsum;
    logic signed [PIX_W+3:0] v;
    res = '0;
    for (int k = 0; k < MAX_CHANNELS; k++) begin
      ctr5 = {1'b0, mid0_r[k], 2'b00} + {3'b000, mid0_r[k]};
      nsum = {2'b00, mid1_r[k]} + {2'b00, mid[k]} + {2'b00, up0_r[k]}
           + {2'b00, low0_r[k]};
      v = $signed({1'b0, ctr5}) - $signed({2'b00, nsum});
      if (interior && (k < 32'(nch))) begin
        if (v[PIX_W+3]) begin
          res[k] = '0;
        end else if (v > $signed(12'd255)) begin
          res[k] = '1;
        end else begin
          res[k] = v[PIX_W-1:0];
        end
      end
    end
  end

endmodule

>>> rtl/shp_out_buf.sv
module shp_out_buf (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  shp_pkg::out_item_t load_item,
  input  logic               load_border,
  input  logic               load_fe,
  output logic               can_load,
  output logic               out_valid,
  input  logic               out_ready,
  output shp_pkg::out_item_t out_data
);
  import shp_pkg::*;

  logic      out_valid_r;
  out_item_t out_data_r;
  logic      pend_r;
  logic      pend_fe_r;
  logic      take;
  out_item_t border_item;

  assign take     = out_valid_r && out_ready;
  assign can_load = !out_valid_r || (take && !pend_r);

  // zero right border pixel closing the row
  always_comb begin
    border_item           = '0;
    border_item.run_last  = 1'b1;
    border_item.frame_end = pend_fe_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      pend_fe_r   <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
      pend_r      <= load_border;
      pend_fe_r   <= load_fe;
    end else if (take) begin
      out_valid_r <= pend_r;
      pend_r      <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= load_item;
    end else if (take && pend_r) begin
      out_data_r <= border_item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
